/* hw/rtl/bpms_pkg.sv */
package bpms_pkg;

   localparam logic [6:0]  STEP_TICKS        = 7'd100;
   localparam logic [11:0] SHORT_PRESS_TICKS = 12'd1000;
   localparam logic [11:0] ALARM_PRESS_TICKS = 12'd3000;
   localparam logic [11:0] HOLD_MAX          = 12'd4095;

   localparam logic [1:0] CSR_RING_UNITS  = 2'd0;
   localparam logic [1:0] CSR_GAP_UNITS   = 2'd1;
   localparam logic [1:0] CSR_PAUSE_UNITS = 2'd2;
   localparam logic [1:0] CSR_INVERT_BELL = 2'd3;

   localparam logic [2:0] PH_RING1      = 3'd0;
   localparam logic [2:0] PH_RING2      = 3'd2;
   localparam logic [1:0] PH_SLOT_GAP   = 2'd1;
   localparam logic [1:0] PH_SLOT_LAST  = 2'd3;
   localparam logic [2:0] PH_REP_RING1  = 3'd4;
   localparam logic [2:0] PH_REP_PAUSE  = 3'd7;

   typedef enum logic [2:0] {
      RUN_WAIT       = 3'd0,
      RUN_DING       = 3'd1,
      RUN_PEND_CONT  = 3'd2,
      RUN_CONT       = 3'd3,
      RUN_PEND_ALARM = 3'd4,
      RUN_ALARM      = 3'd5
   } mode_type;

   typedef struct packed {
      logic red;
      logic blue;
      logic green;
      logic bell;
   } lamp_type;

   localparam lamp_type LAMP_GREEN = '{red: 1'b0, blue: 1'b0, green: 1'b1, bell: 1'b0};
   localparam lamp_type LAMP_ALARM = '{red: 1'b1, blue: 1'b0, green: 1'b0, bell: 1'b1};

   typedef struct packed {
      logic [7:0] ring_units;
      logic [7:0] gap_units;
      logic [7:0] pause_units;
      logic       invert_bell;
   } cfg_type;

   typedef struct packed {
      logic bell_pin;
      logic green_lit;
      logic blue_lit;
      logic red_lit;
      logic pattern_active;
   } rsp_type;

   typedef struct packed {
      logic       finish;
      logic       lv_wr;
      lamp_type   lv;
      logic [2:0] phase;
      logic [7:0] cnt;
      logic [6:0] step;
   } pstep_type;

   function automatic pstep_type play_step(input logic [2:0] phase, input logic [7:0] cnt,
                                           input cfg_type cfg);
      pstep_type  r;
      logic [2:0] ph;
      logic [7:0] uc;
      logic [7:0] lim;
      logic       rep;
      logic       stop;
      r    = '0;
      ph   = phase;
      uc   = cnt;
      stop = 1'b0;
      lim  = 8'd0;
      rep  = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (!stop) begin
            rep = ph[2];
            case (ph[1:0])
               PH_SLOT_GAP:   lim = cfg.gap_units;
               PH_SLOT_LAST:  lim = cfg.pause_units;
               default:       lim = cfg.ring_units;
            endcase
            if ((ph[1:0] == PH_SLOT_LAST && !rep) || (uc >= lim && ph == PH_RING2)) begin
               r.finish = 1'b1;
               r.lv_wr  = 1'b1;
               r.lv     = '0;
               r.phase  = PH_RING1;
               r.cnt    = 8'd0;
               r.step   = 7'd0;
               stop     = 1'b1;
            end else if (uc < lim) begin
               r.lv_wr  = 1'b1;
               r.lv     = '{red: 1'b0, blue: rep, green: !rep, bell: !ph[0]};
               r.phase  = ph;
               r.cnt    = uc + 8'd1;
               r.step   = STEP_TICKS;
               stop     = 1'b1;
            end else if (ph == PH_REP_PAUSE) begin
               r.phase  = PH_REP_RING1;
               r.cnt    = 8'd0;
               r.step   = 7'd0;
               stop     = 1'b1;
            end else begin
               ph = ph + 3'd1;
               uc = 8'd0;
            end
         end
      end
      return r;
   endfunction

endpackage

/* hw/rtl/bpms_core.sv */
module bpms_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              button_level,
   input  bpms_pkg::cfg_type cfg,
   output bpms_pkg::rsp_type result
);

   bpms_pkg::mode_type  mode_ff, mode_in;
   logic                was_down_ff, was_down_in;
   logic [11:0]         hold_ff, hold_in;
   logic                pend_ff, pend_in;
   logic                run_ff, run_in;
   logic [2:0]          phase_ff, phase_in;
   logic [7:0]          cnt_ff, cnt_in;
   logic [6:0]          step_ff, step_in;
   bpms_pkg::lamp_type  lv_ff, lv_in;
   bpms_pkg::pstep_type ps;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= bpms_pkg::RUN_WAIT;
         was_down_ff <= 1'b0;
         hold_ff     <= '0;
         pend_ff     <= 1'b0;
         run_ff      <= 1'b0;
         phase_ff    <= bpms_pkg::PH_RING1;
         cnt_ff      <= '0;
         step_ff     <= '0;
         lv_ff       <= bpms_pkg::LAMP_GREEN;
      end else if (step_en) begin
         mode_ff     <= mode_in;
         was_down_ff <= was_down_in;
         hold_ff     <= hold_in;
         pend_ff     <= pend_in;
         run_ff      <= run_in;
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         step_ff     <= step_in;
         lv_ff       <= lv_in;
      end
   end

   assign ps = bpms_pkg::play_step(phase_ff, cnt_ff, cfg);

   always_comb begin
      mode_in     = mode_ff;
      was_down_in = was_down_ff;
      hold_in     = hold_ff;
      pend_in     = pend_ff;
      run_in      = run_ff;
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      lv_in       = lv_ff;
      step_in     = (step_ff != 7'd0) ? step_ff - 7'd1 : 7'd0;

      if (!button_level) begin
         if (!was_down_ff) begin
            was_down_in = 1'b1;
            hold_in     = '0;
         end else begin
            hold_in = (hold_ff != bpms_pkg::HOLD_MAX) ? hold_ff + 12'd1 : hold_ff;
            if (hold_in > bpms_pkg::SHORT_PRESS_TICKS &&
                hold_in < bpms_pkg::ALARM_PRESS_TICKS) begin
               lv_in   = '{red: 1'b0, blue: 1'b1, green: 1'b0, bell: lv_ff.bell};
               mode_in = bpms_pkg::RUN_PEND_CONT;
            end else if (hold_in > bpms_pkg::ALARM_PRESS_TICKS) begin
               lv_in   = '{red: 1'b1, blue: 1'b0, green: 1'b0, bell: lv_ff.bell};
               mode_in = bpms_pkg::RUN_PEND_ALARM;
            end
         end
      end else if (was_down_ff) begin
         was_down_in = 1'b0;
         hold_in = (hold_ff != bpms_pkg::HOLD_MAX) ? hold_ff + 12'd1 : hold_ff;
         if (hold_in < bpms_pkg::SHORT_PRESS_TICKS) begin
            unique case (mode_ff) inside
               bpms_pkg::RUN_CONT, bpms_pkg::RUN_ALARM,
               bpms_pkg::RUN_PEND_CONT, bpms_pkg::RUN_PEND_ALARM: begin
                  mode_in = bpms_pkg::RUN_WAIT;
                  lv_in   = '{red: 1'b0, blue: 1'b0, green: 1'b1, bell: lv_ff.bell};
                  run_in  = 1'b0;
               end
               default: begin
                  mode_in = bpms_pkg::RUN_DING;
                  run_in  = 1'b1;
               end
            endcase
            pend_in = 1'b1;
         end else if (mode_ff == bpms_pkg::RUN_PEND_CONT) begin
            mode_in = bpms_pkg::RUN_CONT;
            lv_in   = '{red: 1'b0, blue: 1'b1, green: 1'b0, bell: lv_ff.bell};
            pend_in = 1'b1;
            run_in  = 1'b1;
         end else if (mode_ff == bpms_pkg::RUN_PEND_ALARM) begin
            mode_in = bpms_pkg::RUN_ALARM;
            lv_in   = '{red: 1'b1, blue: 1'b0, green: 1'b0, bell: lv_ff.bell};
            pend_in = 1'b1;
            run_in  = 1'b0;
         end
      end

      if (pend_in) begin
         unique case (mode_in)
            bpms_pkg::RUN_WAIT: begin
               pend_in = 1'b0;
               lv_in   = bpms_pkg::LAMP_GREEN;
               run_in  = 1'b0;
            end
            bpms_pkg::RUN_DING: begin
               pend_in  = 1'b0;
               phase_in = bpms_pkg::PH_RING1;
               cnt_in   = '0;
               run_in   = 1'b1;
            end
            bpms_pkg::RUN_CONT: begin
               pend_in  = 1'b0;
               phase_in = bpms_pkg::PH_REP_RING1;
               cnt_in   = '0;
               run_in   = 1'b1;
            end
            bpms_pkg::RUN_ALARM: begin
               pend_in = 1'b0;
               lv_in   = bpms_pkg::LAMP_ALARM;
               run_in  = 1'b0;
            end
            default: ;
         endcase
      end else if (run_in && step_in == 7'd0) begin
         phase_in = ps.phase;
         cnt_in   = ps.cnt;
         step_in  = ps.step;
         if (ps.lv_wr) begin
            lv_in = ps.lv;
         end
         if (ps.finish) begin
            run_in  = 1'b0;
            mode_in = bpms_pkg::RUN_WAIT;
            pend_in = 1'b1;
         end
      end

      result.bell_pin       = ~(lv_in.bell ^ cfg.invert_bell);
      result.green_lit      = lv_in.green;
      result.blue_lit       = lv_in.blue;
      result.red_lit        = lv_in.red;
      result.pattern_active = run_in;
   end

endmodule

/* hw/rtl/bpms_skid.sv */
module bpms_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bpms_pkg::rsp_type push_data,
   output logic              full,
   output logic              out_valid,
   input  logic              out_stall,
   output bpms_pkg::rsp_type out_data
);

   logic              head_valid_ff, head_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   bpms_pkg::rsp_type head_ff, head_in;
   bpms_pkg::rsp_type skid_ff, skid_in;
   logic              take;

   assign take = head_valid_ff & ~out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (push) begin
         if (!head_valid_ff || take) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = 1'b0;
         end
      end
   end

   assign full      = skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

endmodule

/* hw/rtl/bell_press_mode_sequencer.sv */
// result: each accepted tick word's result word is registered into the result buffer
// throughput: one tick word per cycle; a two-entry result buffer lets a new
// tick in while one result waits, and the tick side stalls only when both are full
// reset: synchronous, active high; mode wait, green lamp lit, bell off,
// registers back to ring 1, gap 2, pause 7, bell active low
module bell_press_mode_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_button_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_bell_pin,
   output logic       rsp_green_lit,
   output logic       rsp_blue_lit,
   output logic       rsp_red_lit,
   output logic       rsp_pattern_active,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   bpms_pkg::cfg_type cfg_ff, cfg_in;
   bpms_pkg::rsp_type core_rsp;
   bpms_pkg::rsp_type out_rsp;
   logic              accept;
   logic              full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{ring_units: 8'd1, gap_units: 8'd2, pause_units: 8'd7,
                     invert_bell: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bpms_pkg::CSR_RING_UNITS:  cfg_in.ring_units  = csr_data;
            bpms_pkg::CSR_GAP_UNITS:   cfg_in.gap_units   = csr_data;
            bpms_pkg::CSR_PAUSE_UNITS: cfg_in.pause_units = csr_data;
            bpms_pkg::CSR_INVERT_BELL: cfg_in.invert_bell = csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_stall = full;
   assign accept    = req_valid & ~full;

   bpms_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (accept),
      .button_level (req_button_level),
      .cfg          (cfg_ff),
      .result       (core_rsp)
   );

   bpms_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_rsp),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_rsp)
   );

   assign rsp_bell_pin       = out_rsp.bell_pin;
   assign rsp_green_lit      = out_rsp.green_lit;
   assign rsp_blue_lit       = out_rsp.blue_lit;
   assign rsp_red_lit        = out_rsp.red_lit;
   assign rsp_pattern_active = out_rsp.pattern_active;

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted tick produced no result word");

   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("tick side stalled with no result waiting");

   a_fill_on_blocked: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && rsp_valid && rsp_stall |=> req_stall)
      else $error("result buffer lost a word");

   a_one_lamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_green_lit, rsp_blue_lit, rsp_red_lit}))
      else $error("more than one lamp lit");

endmodule
